// File: src/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("%m");
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("%m");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, b)
`define ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

// File: src/aes256_pkg.sv
// Package: AES constants, S-box functions and shared types
`timescale 1ns / 1ps
package aes256_pkg;
    localparam int KeyWords = 8;
    localparam int Rounds   = 14;
    localparam int RkCount  = 4 * (Rounds + 1);
    localparam int RkAw     = $clog2(RkCount);
    localparam int RndW     = $clog2(Rounds + 1);
    localparam int KwW      = $clog2(KeyWords);
    localparam logic [7:0] Poly = 8'h1b;
    localparam logic [7:0] TopBit = 8'h80;
    localparam logic [1:0] RegKey0 = 2'd0;
    localparam logic [1:0] RegKey1 = 2'd1;
    localparam logic [1:0] RegKey2 = 2'd2;
    localparam logic [1:0] RegKey3 = 2'd3;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = (a & TopBit) != 8'h00 ? ({a[6:0], 1'b0} ^ Poly) : {a[6:0], 1'b0};
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = '0;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = xtime(x);
        end
        gmul = p;
    endfunction

    function automatic logic [7:0] ginv(input logic [7:0] x);
        logic [7:0] r;
        r = x;
        for (int i = 0; i < 253; i++) r = gmul(r, x);
        ginv = r;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
        rotl8 = (v << n) | (v >> (8 - n));
    endfunction

    function automatic logic [7:0] sbox_calc(input logic [7:0] x);
        logic [7:0] v;
        v = ginv(x);
        sbox_calc = v ^ rotl8(v, 1) ^ rotl8(v, 2) ^ rotl8(v, 3) ^ rotl8(v, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] isbox_calc(input logic [7:0] y);
        isbox_calc = ginv(rotl8(y, 1) ^ rotl8(y, 3) ^ rotl8(y, 6) ^ 8'h05);
    endfunction

    typedef logic [7:0] t_tab [256];

    function automatic t_tab mk_sbox(input logic inv);
        t_tab t;
        for (int i = 0; i < 256; i++)
            t[i] = inv ? isbox_calc(8'(i)) : sbox_calc(8'(i));
        mk_sbox = t;
    endfunction

    localparam t_tab SBox  = mk_sbox(1'b0);
    localparam t_tab ISBox = mk_sbox(1'b1);

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBox[w[31:24]], SBox[w[23:16]], SBox[w[15:8]], SBox[w[7:0]]};
    endfunction

    typedef struct packed {
        logic         we;
        logic [RkAw-1:0] waddr;
        logic [31:0]  wdata;
    } t_rk_wr;
endpackage

// File: src/aes256_if.sv
// Valid/ready channel interfaces for blocks in and results out
`timescale 1ns / 1ps
interface aes256_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
    modport source (output valid, func, block_hi, block_lo, input ready);
    modport sink   (input valid, func, block_hi, block_lo, output ready);
endinterface

interface aes256_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_hi;
    logic [63:0] result_lo;
    modport source (output valid, result_hi, result_lo, input ready);
    modport sink   (input valid, result_hi, result_lo, output ready);
endinterface

// File: src/aes256_keyexp.sv
// Key expansion sequencer: one round-key word per cycle
`timescale 1ns / 1ps
module aes256_keyexp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [255:0]  i_key,
    output logic          o_busy,
    output aes256_pkg::t_rk_wr o_wr
);
    logic [aes256_pkg::RkAw-1:0] r_idx, n_idx;
    logic r_busy, n_busy;
    logic [7:0] r_rcon, n_rcon;
    logic [31:0] r_win [aes256_pkg::KeyWords];
    logic [31:0] n_win [aes256_pkg::KeyWords];
    logic [31:0] t, w;
    logic [aes256_pkg::KwW-1:0] pos;

    // window holds the last KeyWords words produced
    always_comb begin
        pos = r_idx[aes256_pkg::KwW-1:0];
        t = r_win[aes256_pkg::KeyWords-1];
        if (pos == '0)
            t = aes256_pkg::sub_word({t[23:0], t[31:24]}) ^ {r_rcon, 24'h0};
        else if (aes256_pkg::KeyWords > 6 && pos == aes256_pkg::KwW'(4))
            t = aes256_pkg::sub_word(t);
        w = r_win[0] ^ t;
        n_idx = r_idx;
        n_busy = r_busy;
        n_rcon = r_rcon;
        for (int k = 0; k < aes256_pkg::KeyWords; k++) n_win[k] = r_win[k];
        o_wr.we = 1'b0;
        o_wr.waddr = r_idx;
        o_wr.wdata = w;
        if (i_start) begin
            n_busy = 1'b1;
            n_idx = '0;
            n_rcon = 8'h01;
            for (int k = 0; k < aes256_pkg::KeyWords; k++)
                n_win[k] = i_key[255-32*k -: 32];
        end else if (r_busy) begin
            o_wr.we = 1'b1;
            if (r_idx < aes256_pkg::RkAw'(aes256_pkg::KeyWords)) begin
                o_wr.wdata = r_win[r_idx[aes256_pkg::KwW-1:0]];
            end else begin
                for (int k = 0; k < aes256_pkg::KeyWords - 1; k++) n_win[k] = r_win[k+1];
                n_win[aes256_pkg::KeyWords-1] = w;
                if (pos == '0) n_rcon = aes256_pkg::xtime(r_rcon);
            end
            if (r_idx == aes256_pkg::RkAw'(aes256_pkg::KeyWords - 1)) begin
                // drop into sliding mode with the key words as window
            end
            n_idx = r_idx + 1'b1;
            if (r_idx == aes256_pkg::RkAw'(aes256_pkg::RkCount - 1)) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_idx <= n_idx;
        r_rcon <= n_rcon;
        for (int k = 0; k < aes256_pkg::KeyWords; k++) r_win[k] <= n_win[k];
    end

    assign o_busy = r_busy;
endmodule

// File: src/aes256_block_cipher.sv
// AES-256 block cipher top level
// Usage: write the 256-bit key through the APB port as four 64-bit registers
// at byte addresses 0, 8, 16, 24 (key bytes 0..7 first, byte 0 in the top bits).
// Blocks arrive on in_ch (func 0 encrypt, 1 decrypt) and results leave on
// out_ch; a transaction completes when valid and ready are both high.
// One shared round unit, used once per round. Each of the 15 key additions
// (initial plus 14 rounds) fetches the four round-key words one word per
// cycle from the 60-word store, waits for the last read to land and then
// applies the round. After reset or any key write the first block first
// runs the key expansion, one word per cycle.
// Reset clears the control state; keys reset to zero. in_ch is not ready while
// a block is in flight. While the receiver stalls, the result is held and no
// new block is accepted.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aes256_block_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    aes256_in_if.sink   in_ch,
    aes256_out_if.source out_ch
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_KEXP  = 6'b000010,
        ST_FETCH = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_OUT   = 6'b010000,
        ST_KWAIT = 6'b100000
    } t_state;

    t_state r_st, n_st;
    logic [63:0] r_key [4];
    logic r_kready;
    logic r_dec;
    logic [127:0] r_s, n_s;
    logic [aes256_pkg::RndW-1:0] r_rnd, n_rnd;
    logic [1:0] r_col, n_col;
    logic [127:0] r_rk, n_rk;
    logic [31:0] rk_mem [aes256_pkg::RkCount];
    logic [31:0] r_rdata;
    logic [aes256_pkg::RkAw-1:0] raddr;
    logic kx_start, kx_busy;
    aes256_pkg::t_rk_wr kx_wr;
    logic cfg_wr;
    logic [1:0] reg_idx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign reg_idx = paddr[4:3];
    always_comb begin
        case (reg_idx)
            aes256_pkg::RegKey0: prdata = r_key[0];
            aes256_pkg::RegKey1: prdata = r_key[1];
            aes256_pkg::RegKey2: prdata = r_key[2];
            aes256_pkg::RegKey3: prdata = r_key[3];
            default:             prdata = '0;
        endcase
    end

    aes256_keyexp u_kx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(kx_start),
        .i_key({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .o_busy(kx_busy), .o_wr(kx_wr)
    );

    always_ff @(posedge i_clk) begin
        if (kx_wr.we) rk_mem[kx_wr.waddr] <= kx_wr.wdata;
        r_rdata <= rk_mem[raddr];
    end

    // state byte k at bits 127-8k; column c is bytes 4c..4c+3
    function automatic logic [7:0] sb(input logic [127:0] s, input int k);
        sb = s[127-8*k -: 8];
    endfunction

    function automatic logic [127:0] fwd_round(input logic [127:0] s, input logic mix);
        logic [7:0] a [16];
        logic [7:0] b [16];
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                a[4*c+r] = aes256_pkg::SBox[sb(s, 4*((c+r)%4)+r)];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                b[4*c+r] = mix ? (aes256_pkg::xtime(a[4*c+r]) ^ aes256_pkg::xtime(a[4*c+(r+1)%4])
                           ^ a[4*c+(r+1)%4] ^ a[4*c+(r+2)%4] ^ a[4*c+(r+3)%4]) : a[4*c+r];
        for (int k = 0; k < 16; k++) o[127-8*k -: 8] = b[k];
        fwd_round = o;
    endfunction

    function automatic logic [127:0] inv_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic mix);
        logic [7:0] a [16];
        logic [7:0] b [16];
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                a[4*c+r] = aes256_pkg::ISBox[sb(s, 4*((c+4-r)%4)+r)] ^ sb(rk, 4*c+r);
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                b[4*c+r] = mix ? (aes256_pkg::gmul(8'd14, a[4*c+r])
                           ^ aes256_pkg::gmul(8'd11, a[4*c+(r+1)%4])
                           ^ aes256_pkg::gmul(8'd13, a[4*c+(r+2)%4])
                           ^ aes256_pkg::gmul(8'd9, a[4*c+(r+3)%4])) : a[4*c+r];
        for (int k = 0; k < 16; k++) o[127-8*k -: 8] = b[k];
        inv_round = o;
    endfunction

    // key index for the round being fetched
    logic [aes256_pkg::RndW-1:0] krnd;
    always_comb begin
        krnd = r_dec ? aes256_pkg::RndW'(aes256_pkg::Rounds) - r_rnd : r_rnd;
        raddr = aes256_pkg::RkAw'({krnd, 2'b00}) + aes256_pkg::RkAw'(r_col);
    end

    logic r_rvalid;
    always_comb begin
        n_st = r_st;
        n_s = r_s;
        n_rnd = r_rnd;
        n_col = r_col;
        n_rk = r_rk;
        kx_start = 1'b0;
        if (r_rvalid) n_rk = {r_rk[95:0], r_rdata};
        case (r_st)
            ST_IDLE: begin
                if (in_ch.valid) begin
                    n_s = {in_ch.block_hi, in_ch.block_lo};
                    n_rnd = '0;
                    n_col = '0;
                    if (!r_kready) begin
                        kx_start = 1'b1;
                        n_st = ST_KWAIT;
                    end else begin
                        n_st = ST_FETCH;
                    end
                end
            end
            ST_KWAIT: n_st = ST_KEXP;
            ST_KEXP: if (!kx_busy) n_st = ST_FETCH;
            ST_FETCH: begin
                n_col = r_col + 1'b1;
                if (r_col == 2'd3) n_st = ST_ROUND;
            end
            ST_ROUND: begin
                // wait for last word of this round's key to land
                if (!r_rvalid) begin
                    if (r_rnd == '0)
                        n_s = r_s ^ r_rk;
                    else if (!r_dec)
                        n_s = fwd_round(r_s, r_rnd != aes256_pkg::RndW'(aes256_pkg::Rounds))
                              ^ r_rk;
                    else
                        n_s = inv_round(r_s, r_rk,
                                        r_rnd != aes256_pkg::RndW'(aes256_pkg::Rounds));
                    if (r_rnd == aes256_pkg::RndW'(aes256_pkg::Rounds)) begin
                        n_st = ST_OUT;
                    end else begin
                        n_rnd = r_rnd + 1'b1;
                        n_col = '0;
                        n_st = ST_FETCH;
                    end
                end
            end
            ST_OUT: if (out_ch.ready) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_kready <= 1'b0;
            r_rvalid <= 1'b0;
            for (int k = 0; k < 4; k++) r_key[k] <= '0;
        end else begin
            r_st <= n_st;
            r_rvalid <= (r_st == ST_FETCH);
            if (cfg_wr) begin
                r_key[reg_idx] <= pwdata;
                r_kready <= 1'b0;
            end else if (kx_start) begin
                r_kready <= 1'b1;
            end
        end
        if (r_st == ST_IDLE && in_ch.valid) r_dec <= in_ch.func;
        r_s <= n_s;
        r_rnd <= n_rnd;
        r_col <= n_col;
        r_rk <= n_rk;
    end

    assign in_ch.ready = (r_st == ST_IDLE);
    assign out_ch.valid = (r_st == ST_OUT);
    assign out_ch.result_hi = r_s[127:64];
    assign out_ch.result_lo = r_s[63:0];

    `ASSERT_IMPLIES(a_no_kx_in_round, i_clk, i_rst_n, r_st == ST_ROUND || r_st == ST_FETCH, !kx_busy)
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(r_s))
    `ASSERT_IMPLIES(a_rdy_excl, i_clk, i_rst_n, in_ch.ready, !out_ch.valid)
endmodule
